// ===== sv/hed_pkg.sv =====
// Shared types, constants and entity tables for the HTML entity decoder.
package hed_pkg;

    localparam int CHAR_W  = 8;
    localparam int CNT_W   = 12;
    localparam int N_SLOTS = 6;   // most decoded bytes one text byte can cause
    localparam int N_PEND  = 5;   // held entity bytes
    localparam int N_ENT   = 6;

    // Decoder mode, one-hot
    typedef enum logic [4:0] {
        M_PLAIN = 5'b00001,
        M_NAMED = 5'b00010,
        M_HASH  = 5'b00100,
        M_DEC   = 5'b01000,
        M_HEX   = 5'b10000
    } mode_t;

    // One request from front to back: bytes to put, then optional end report
    typedef struct packed {
        logic [N_SLOTS-1:0][CHAR_W-1:0] chars;
        logic [2:0]                     n;
        logic                           fin;
    } cmd_t;

    localparam logic [CHAR_W-1:0] CH_AMP  = 8'h26;
    localparam logic [CHAR_W-1:0] CH_HASH = 8'h23;
    localparam logic [CHAR_W-1:0] CH_SEMI = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_QST  = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_LX   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX   = 8'h58;

    // Entity names after '&', closing ';' included
    localparam logic [CHAR_W-1:0] ENT_TEXT [N_ENT][N_PEND] = '{
        '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // lt;
        '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // gt;
        '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},   // amp;
        '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},   // quot;
        '{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},   // apos;
        '{8'h6E, 8'h62, 8'h73, 8'h70, 8'h3B}    // nbsp;
    };
    localparam logic [2:0] ENT_LEN [N_ENT] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd5};
    localparam logic [CHAR_W-1:0] ENT_CHAR [N_ENT] = '{
        8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27, 8'h20
    };

    function automatic logic [CHAR_W-1:0] lower_ch(input logic [CHAR_W-1:0] c);
        lower_ch = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

endpackage

// ===== sv/html_entity_decoder.sv =====
// Top level of the HTML entity decoder: front end, request queue, back end, config.
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-----------------------------
//  input   | char_in, end_of_text                      | in_valid / in_stall
//  result  | out_char, out_valid, run_last, text_end,  | res_valid / res_stall
//          | out_count, truncated                      |
//  config  | output_limit                              | cfg_valid / cfg_ready (=1)
//
//  One text byte is taken per cycle while in_stall is low. The back end delivers one result
//  per cycle while res_stall is low, so a byte that flushes held entity bytes (up to 6
//  results plus an end report) holds the back end while they go out; the two-entry request
//  queue then fills and in_stall rises. Results are registered from the queue head.
//  Reset clears parsing state, the queue, the counters; the limit resets to 255.
//  in_stall depends only on queue fullness, never on res_stall directly.
module html_entity_decoder
    import hed_pkg::*;
#(
    parameter int MAX_OUTPUT = 4095
)
(
    input  logic              clk,
    input  logic              rst_n,
    // text input
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              end_of_text,
    // results
    output logic              res_valid,
    input  logic              res_stall,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_valid,
    output logic              run_last,
    output logic              text_end,
    output logic [CNT_W-1:0]  out_count,
    output logic              truncated,
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  output_limit
);

    // limit in force: smaller of the register and MAX_OUTPUT, capped at 4095
    localparam int MAX_LIM = (MAX_OUTPUT > 4095) ? 4095 : MAX_OUTPUT;

    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] lim;
    logic             acc, push, pop, full, head_valid;
    cmd_t             wr_cmd, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= CNT_W'(255);
        else if (cfg_valid && cfg_ready)
            limit_reg <= output_limit;
    end

    assign lim = (limit_reg < CNT_W'(MAX_LIM)) ? limit_reg : CNT_W'(MAX_LIM);

    // accept whenever the queue has room
    assign in_stall = full;
    assign acc      = in_valid && !in_stall;

    hed_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .char_in     (char_in),
        .end_of_text (end_of_text),
        .push        (push),
        .cmd         (wr_cmd)
    );

    hed_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_cmd     (wr_cmd),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    hed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .lim        (lim),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .out_char   (out_char),
        .out_valid  (out_valid),
        .run_last   (run_last),
        .text_end   (text_end),
        .out_count  (out_count),
        .truncated  (truncated)
    );

endmodule

// ===== sv/hed_front.sv =====
// Front end: tracks entity parsing and turns each text byte into a put request.
module hed_front
    import hed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              acc,
    input  logic [CHAR_W-1:0] char_in,
    input  logic              end_of_text,
    output logic              push,
    output cmd_t              cmd
);

    mode_t             mode_reg, mode_next;
    logic [2:0]        pcnt_reg, pcnt_next;
    logic [CHAR_W-1:0] ev_reg, ev_next;
    logic [CHAR_W-1:0] pend_reg  [N_PEND];
    logic [CHAR_W-1:0] pend_next [N_PEND];

    logic [CHAR_W-1:0]              lc;
    logic [2:0]                     k;
    logic                           any_full, any_prefix;
    logic [CHAR_W-1:0]              full_char;
    logic                           is_hex, is_dig;
    logic [3:0]                     dig;
    logic [CHAR_W-1:0]              ev_in;
    logic [CNT_W-1:0]               acc_val;
    logic [CHAR_W-1:0]              num_char;
    logic                           plain_c, num_go;
    logic [N_SLOTS-1:0][CHAR_W-1:0] lst;
    logic [2:0]                     lcnt;

    function automatic logic [CHAR_W-1:0] num_out(input logic [CHAR_W-1:0] v);
        num_out = (v != '0 && v[CHAR_W-1] == 1'b0) ? v : CH_QST;
    endfunction

    // Named entity match against held bytes
    always_comb
    begin
        logic ok;
        lc         = lower_ch(char_in);
        k          = pcnt_reg - 3'd1;
        any_full   = 1'b0;
        any_prefix = 1'b0;
        full_char  = '0;
        for (int i = 0; i < N_ENT; i++)
        begin
            ok = (k < ENT_LEN[i]) && (k < 3'(N_PEND)) && (lc == ENT_TEXT[i][k]);
            for (int j = 0; j < N_PEND - 1; j++)
            begin
                if (3'(j) < k && lower_ch(pend_reg[j+1]) != ENT_TEXT[i][j])
                    ok = 1'b0;
            end
            if (ok && (k + 3'd1 == ENT_LEN[i]))
            begin
                any_full  = 1'b1;
                full_char = ENT_CHAR[i];
            end
            else if (ok)
                any_prefix = 1'b1;
        end
    end

    // Numeric digit and accumulate
    always_comb
    begin
        is_hex = (mode_reg == M_HEX);
        ev_in  = (mode_reg == M_HASH) ? '0 : ev_reg;
        is_dig = 1'b0;
        dig    = '0;
        if (char_in inside {[8'h30:8'h39]})
        begin
            is_dig = 1'b1;
            dig    = 4'(char_in - 8'h30);
        end
        else if (is_hex && char_in inside {[8'h61:8'h66]})
        begin
            is_dig = 1'b1;
            dig    = 4'(char_in - 8'h57);
        end
        else if (is_hex && char_in inside {[8'h41:8'h46]})
        begin
            is_dig = 1'b1;
            dig    = 4'(char_in - 8'h37);
        end
        if (is_hex)
            acc_val = {ev_in, 4'b0000} + CNT_W'(dig);
        else
            acc_val = {1'b0, ev_in, 3'b000} + {3'b000, ev_in, 1'b0} + CNT_W'(dig);
        num_char = num_out(ev_in);
    end

    always_comb
    begin
        mode_next = mode_reg;
        pcnt_next = pcnt_reg;
        ev_next   = ev_reg;
        pend_next = pend_reg;
        lst       = '0;
        lcnt      = '0;
        plain_c   = 1'b0;
        num_go    = 1'b0;

        case (mode_reg)
            M_NAMED:
            begin
                if (pcnt_reg == 3'd1 && char_in == CH_HASH)
                begin
                    pend_next[1] = char_in;
                    pcnt_next    = 3'd2;
                    mode_next    = M_HASH;
                end
                else if (any_full)
                begin
                    lst[0]    = full_char;
                    lcnt      = 3'd1;
                    pcnt_next = '0;
                    mode_next = M_PLAIN;
                end
                else if (any_prefix && pcnt_reg < 3'(N_PEND))
                begin
                    pend_next[pcnt_reg] = char_in;
                    pcnt_next           = pcnt_reg + 3'd1;
                end
                else
                begin
                    for (int i = 0; i < N_PEND; i++)
                        lst[i] = pend_reg[i];
                    lcnt      = pcnt_reg;
                    pcnt_next = '0;
                    mode_next = M_PLAIN;
                    plain_c   = 1'b1;
                end
            end
            M_HASH:
            begin
                pcnt_next = '0;
                ev_next   = '0;
                if (char_in == CH_LX || char_in == CH_UX)
                    mode_next = M_HEX;
                else
                begin
                    mode_next = M_DEC;
                    num_go    = 1'b1;
                end
            end
            M_DEC, M_HEX:
                num_go = 1'b1;
            default:
            begin
                mode_next = M_PLAIN;
                plain_c   = 1'b1;
            end
        endcase

        if (num_go)
        begin
            if (is_dig)
                ev_next = (acc_val > CNT_W'(255)) ? 8'hFF : acc_val[CHAR_W-1:0];
            else
            begin
                lst[lcnt] = num_char;
                lcnt      = lcnt + 3'd1;
                ev_next   = '0;
                mode_next = M_PLAIN;
                plain_c   = (char_in != CH_SEMI);
            end
        end

        if (plain_c)
        begin
            if (char_in == CH_AMP)
            begin
                pend_next[0] = CH_AMP;
                pcnt_next    = 3'd1;
                mode_next    = M_NAMED;
            end
            else
            begin
                lst[lcnt] = char_in;
                lcnt      = lcnt + 3'd1;
            end
        end

        if (end_of_text)
        begin
            if (mode_next == M_NAMED || mode_next == M_HASH)
            begin
                // several held bytes only arise when nothing was put yet
                if (lcnt == '0)
                begin
                    for (int i = 0; i < N_PEND; i++)
                        lst[i] = pend_next[i];
                    lcnt = pcnt_next;
                end
                else
                begin
                    lst[lcnt] = pend_next[0];
                    lcnt      = lcnt + 3'd1;
                end
            end
            else if (mode_next == M_DEC || mode_next == M_HEX)
            begin
                lst[lcnt] = num_out(ev_next);
                lcnt      = lcnt + 3'd1;
            end
            mode_next = M_PLAIN;
            pcnt_next = '0;
            ev_next   = '0;
        end
    end

    assign cmd.chars = lst;
    assign cmd.n     = lcnt;
    assign cmd.fin   = end_of_text;
    assign push      = acc && (lcnt != '0 || end_of_text);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_PLAIN;
            pcnt_reg <= '0;
            ev_reg   <= '0;
        end
        else if (acc)
        begin
            mode_reg <= mode_next;
            pcnt_reg <= pcnt_next;
            ev_reg   <= ev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            pend_reg <= pend_next;
    end

    a_named_holds: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_NAMED |-> (pcnt_reg != '0 && pcnt_reg <= 3'(N_PEND)))
        else $error("named mode with bad held byte count");

endmodule

// ===== sv/hed_cmd_fifo.sv =====
// Two-entry request queue between front and back.
module hed_cmd_fifo
    import hed_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_cmd,
    input  logic pop,
    output cmd_t head,
    output logic head_valid,
    output logic full
);

    localparam int DEPTH = 2;

    cmd_t       mem_reg [DEPTH];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != '0);
    assign full       = (cnt_reg == 2'(DEPTH));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full request queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty request queue");

endmodule

// ===== sv/hed_back.sv =====
// Back end: puts request bytes against the output limit, drives the result register.
module hed_back
    import hed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              head,
    input  logic              head_valid,
    output logic              pop,
    input  logic [CNT_W-1:0]  lim,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_valid,
    output logic              run_last,
    output logic              text_end,
    output logic [CNT_W-1:0]  out_count,
    output logic              truncated
);

    logic [2:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]  emit_reg, emit_next;
    logic              lim_reg, lim_next;
    logic              res_valid_reg, res_valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              oval_reg, oval_next;
    logic              last_reg, last_next;
    logic              tend_reg, tend_next;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic              trunc_reg, trunc_next;

    logic              adv, ld, hit, last_put, end_ld;
    logic [CNT_W-1:0]  cnt_inc;

    assign adv     = !res_valid_reg || !res_stall;
    assign cnt_inc = emit_reg + CNT_W'(1);
    assign hit     = (cnt_inc >= lim);
    assign last_put = (idx_reg + 3'd1 == head.n) || hit;

    always_comb
    begin
        pop        = 1'b0;
        ld         = 1'b0;
        end_ld     = 1'b0;
        idx_next   = idx_reg;
        emit_next  = emit_reg;
        lim_next   = lim_reg;
        char_next  = char_reg;
        oval_next  = oval_reg;
        last_next  = last_reg;
        tend_next  = tend_reg;
        ocnt_next  = ocnt_reg;
        trunc_next = trunc_reg;

        if (adv && head_valid)
        begin
            if (idx_reg < head.n && !lim_reg)
            begin
                if (emit_reg >= lim)
                begin
                    // dropped at the limit; rest of the bytes drop too
                    lim_next = 1'b1;
                    if (!head.fin)
                    begin
                        pop      = 1'b1;
                        idx_next = '0;
                    end
                end
                else
                begin
                    ld         = 1'b1;
                    char_next  = head.chars[idx_reg];
                    oval_next  = 1'b1;
                    tend_next  = 1'b0;
                    ocnt_next  = cnt_inc;
                    trunc_next = hit;
                    last_next  = last_put && !head.fin;
                    emit_next  = cnt_inc;
                    lim_next   = hit;
                    if (last_put && !head.fin)
                    begin
                        pop      = 1'b1;
                        idx_next = '0;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end
            else
            begin
                if (head.fin)
                begin
                    ld         = 1'b1;
                    end_ld     = 1'b1;
                    char_next  = '0;
                    oval_next  = 1'b0;
                    tend_next  = 1'b1;
                    last_next  = 1'b1;
                    ocnt_next  = emit_reg;
                    trunc_next = lim_reg;
                    emit_next  = '0;
                    lim_next   = 1'b0;
                end
                pop      = 1'b1;
                idx_next = '0;
            end
        end

        if (ld)
            res_valid_next = 1'b1;
        else if (adv)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            emit_reg      <= '0;
            lim_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            emit_reg      <= emit_next;
            lim_reg       <= lim_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        oval_reg  <= oval_next;
        last_reg  <= last_next;
        tend_reg  <= tend_next;
        ocnt_reg  <= ocnt_next;
        trunc_reg <= trunc_next;
    end

    assign res_valid = res_valid_reg;
    assign out_char  = char_reg;
    assign out_valid = oval_reg;
    assign run_last  = last_reg;
    assign text_end  = tend_reg;
    assign out_count = ocnt_reg;
    assign truncated = trunc_reg;

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        end_ld |=> (emit_reg == '0 && !lim_reg))
        else $error("text state not cleared after end report");

endmodule

// ===== tb/html_entity_decoder_test.sv =====
// Self-checking testbench for the HTML entity decoder: byte stream in, predicted results out.
`timescale 1ns / 1ps

module html_entity_decoder_test;
    import hed_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int MAX_KEPT       = 4095;  // MAX_OUTPUT of the instance (default)
    localparam int MAX_PER_BYTE   = 7;     // most results one text byte can cause
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request moving anywhere
    localparam int LONG_HOLD      = 200;   // receiver hold-off for the backpressure test
    localparam int SETTLE_CYCLES  = 8;     // pipeline depth allowance before a limit write
    localparam int DRAIN_CYCLES   = 20;
    localparam int PRINT_CAP      = 40;
    localparam int PHASE_ITEMS    = 17;
    localparam int N_PHASES       = 6;

    // One result as seen on the output port
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              byte_vld;
        logic              run_end;
        logic              txt_end;
        logic [CNT_W-1:0]  count;
        logic              trunc;
    } decoded_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [CHAR_W-1:0] char_in;
    logic              end_of_text;
    logic              res_valid;
    logic              res_stall;
    logic [CHAR_W-1:0] out_char;
    logic              out_valid;
    logic              run_last;
    logic              text_end;
    logic [CNT_W-1:0]  out_count;
    logic              truncated;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  output_limit;

    html_entity_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_in      (char_in),
        .end_of_text  (end_of_text),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .out_char     (out_char),
        .out_valid    (out_valid),
        .run_last     (run_last),
        .text_end     (text_end),
        .out_count    (out_count),
        .truncated    (truncated),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .output_limit (output_limit)
    );

    always #CLK_HALF clk = ~clk;

    // Entity names after '&' (closing ';' included) and the byte each decodes to
    string             ent_name  [6] = '{"lt;", "gt;", "amp;", "quot;", "apos;", "nbsp;"};
    logic [CHAR_W-1:0] ent_glyph [6] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27, 8'h20};

    // ------------------------------------------------------------------
    // Decoder shadow state. Updated once per accepted input request, in
    // request order; the limit shadow follows every accepted config write.
    // ------------------------------------------------------------------
    mode_t             dec_mode;
    logic [CHAR_W-1:0] held [5];      // '&' and the name bytes seen so far
    int                held_n;
    int                ent_val;       // numeric entity value, saturating at 255
    int                emitted;       // decoded bytes in the current text
    bit                lim_hit;
    int                limit_reg;

    decoded_t byte_results[$];        // results caused by the byte being predicted
    decoded_t decoded_q[$];           // results still to come out of the block

    int err_count   = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int hold_req    = 0;              // bumped by a test to ask for a long hold-off

    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    task automatic add_result(input logic [CHAR_W-1:0] ch, input logic vld, input logic tend);
        decoded_t r;
        if (byte_results.size() >= MAX_PER_BYTE)
            return;
        r.ch       = ch;
        r.byte_vld = vld;
        r.run_end  = 1'b0;
        r.txt_end  = tend;
        r.count    = emitted[CNT_W-1:0];
        r.trunc    = lim_hit;
        byte_results.push_back(r);
    endtask

    // Emit one decoded byte unless the limit is (or becomes) exhausted
    task automatic put_byte(input logic [CHAR_W-1:0] ch);
        int lim;
        lim = (limit_reg < MAX_KEPT) ? limit_reg : MAX_KEPT;
        if (lim_hit)
            return;
        if (emitted >= lim)
        begin
            lim_hit = 1'b1;
            return;
        end
        emitted++;
        if (emitted >= lim)
            lim_hit = 1'b1;
        add_result(ch, 1'b1, 1'b0);
    endtask

    task automatic put_numeric();
        put_byte((ent_val > 0 && ent_val < 128) ? ent_val[CHAR_W-1:0] : 8'h3F);
    endtask

    // Held name bytes come out literally
    task automatic flush_held();
        for (int i = 0; i < held_n && i < 5; i++)
            put_byte(held[i]);
        held_n   = 0;
        dec_mode = M_PLAIN;
    endtask

    task automatic plain_byte(input logic [CHAR_W-1:0] c);
        if (c == "&")
        begin
            held[0]  = c;
            held_n   = 1;
            dec_mode = M_NAMED;
        end
        else
        begin
            put_byte(c);
        end
    endtask

    task automatic named_byte(input logic [CHAR_W-1:0] c);
        int                k;
        int                len;
        bit                ok;
        bit                prefix;
        logic [CHAR_W-1:0] lc;
        k      = held_n - 1;
        lc     = fold_case(c);
        prefix = 1'b0;
        if (held_n == 1 && c == "#")
        begin
            held[1]  = c;
            held_n   = 2;
            dec_mode = M_HASH;
            return;
        end
        for (int i = 0; i < 6; i++)
        begin
            len = ent_name[i].len();
            if (k + 1 > len)
                continue;
            ok = (lc == ent_name[i][k]);
            for (int j = 0; ok && j < k; j++)
                if (fold_case(held[j + 1]) != ent_name[i][j])
                    ok = 1'b0;
            if (!ok)
                continue;
            if (k + 1 == len)
            begin
                held_n   = 0;
                dec_mode = M_PLAIN;
                put_byte(ent_glyph[i]);
                return;
            end
            prefix = 1'b1;
        end
        if (prefix && held_n < 5)
        begin
            held[held_n] = c;
            held_n++;
            return;
        end
        flush_held();
        plain_byte(c);
    endtask

    task automatic numeric_byte(input logic [CHAR_W-1:0] c);
        int d;
        int base;
        int v;
        base = (dec_mode == M_HEX) ? 16 : 10;
        d    = 16;
        if (c >= "0" && c <= "9")
            d = c - "0";
        else if (base == 16 && c >= "a" && c <= "f")
            d = c - "a" + 10;
        else if (base == 16 && c >= "A" && c <= "F")
            d = c - "A" + 10;
        if (d < base)
        begin
            v       = ent_val * base + d;
            ent_val = (v > 255) ? 255 : v;
            return;
        end
        // non-digit closes the entity; ';' is swallowed, anything else is text
        put_numeric();
        ent_val  = 0;
        dec_mode = M_PLAIN;
        if (c != ";")
            plain_byte(c);
    endtask

    task automatic clear_text_state();
        dec_mode = M_PLAIN;
        held_n   = 0;
        ent_val  = 0;
        emitted  = 0;
        lim_hit  = 1'b0;
    endtask

    // Work out the results of one accepted text byte and queue them
    task automatic predict_decode(input logic [CHAR_W-1:0] c, input logic eot);
        byte_results.delete();
        case (dec_mode)
            M_NAMED: named_byte(c);
            M_HASH:
            begin
                held_n  = 0;
                ent_val = 0;
                if (c == "x" || c == "X")
                begin
                    dec_mode = M_HEX;
                end
                else
                begin
                    dec_mode = M_DEC;
                    numeric_byte(c);
                end
            end
            M_DEC, M_HEX: numeric_byte(c);
            default:
            begin
                dec_mode = M_PLAIN;
                plain_byte(c);
            end
        endcase
        if (eot)
        begin
            // leftovers first, then the end report, then a fresh text
            if (dec_mode == M_NAMED || dec_mode == M_HASH)
                flush_held();
            else if (dec_mode == M_DEC || dec_mode == M_HEX)
                put_numeric();
            add_result(8'h00, 1'b0, 1'b1);
            clear_text_state();
        end
        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].run_end = 1'b1;
        foreach (byte_results[i])
            decoded_q.push_back(byte_results[i]);
    endtask

    // ------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < PRINT_CAP)
            $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Result checker: every result request is compared with the oldest expectation
    decoded_t want_r;
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                report_mismatch("result with nothing expected, out_char", out_char, 0);
            end
            else
            begin
                want_r = decoded_q.pop_front();
                if (out_char !== want_r.ch)
                    report_mismatch("out_char", out_char, want_r.ch);
                if (out_valid !== want_r.byte_vld)
                    report_mismatch("out_valid", out_valid, want_r.byte_vld);
                if (run_last !== want_r.run_end)
                    report_mismatch("run_last", run_last, want_r.run_end);
                if (text_end !== want_r.txt_end)
                    report_mismatch("text_end", text_end, want_r.txt_end);
                if (out_count !== want_r.count)
                    report_mismatch("out_count", out_count, want_r.count);
                if (truncated !== want_r.trunc)
                    report_mismatch("truncated", truncated, want_r.trunc);
            end
        end
    end

    // Watchdog: any request moving on any channel keeps the run alive
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, switching at random between no
    // stall, light, heavy and alternating; a long hold-off on request
    // from a test, counted here.
    // ------------------------------------------------------------------
    int hold_seen  = 0;
    int hold_left  = 0;
    int stall_mode = 0;
    int mode_left  = 0;
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            res_stall = 1'b1;
            hold_left--;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 64);
            end
            mode_left--;
            case (stall_mode)
                0:       res_stall = 1'b0;
                1:       res_stall = ($urandom_range(0, 9) < 3);
                2:       res_stall = ($urandom_range(0, 9) < 7);
                default: res_stall = ~res_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender side. All tasks start and end at a falling edge.
    // ------------------------------------------------------------------

    // Offer one text byte; bursts of random length with random gaps between.
    // Valid stays up across back-to-back requests within a burst.
    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eot);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        in_valid    = 1'b1;
        char_in     = c;
        end_of_text = eot;
        do
            @(posedge clk);
        while (in_stall);
        predict_decode(c, eot);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    function automatic bit pick_eot();
        return ($urandom_range(0, 24) == 0);
    endfunction

    function automatic logic [CHAR_W-1:0] mix_case(input logic [CHAR_W-1:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
            return c - 8'd32;
        return c;
    endfunction

    // Send a string; end of text on the last byte, or at random on any byte
    task automatic send_text(input string s, input bit eot_last, input bit eot_rand);
        bit eot;
        for (int i = 0; i < s.len(); i++)
        begin
            eot = eot_rand ? pick_eot() : (eot_last && i == s.len() - 1);
            send_byte(eot_rand ? mix_case(s[i]) : s[i], eot);
        end
    endtask

    // Block must be idle before a limit write: no request in flight, nothing owed
    task automatic wait_idle();
        in_valid   = 1'b0;
        burst_left = 0;
        while (decoded_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input int value);
        wait_idle();
        cfg_valid    = 1'b1;
        output_limit = value[CNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        limit_reg = value & 32'hFFF;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Mixed-case named entity, hex entity cut by a non-digit, empty numeric
    // entity, and a partial name flushed by end of text
    task automatic test_entity_forms();
        send_text("&lT;&#x4g&#;&quo", 1'b1, 1'b0);
    endtask

    // Byte extremes, then a decimal entity that saturates, closed by end of text
    task automatic test_byte_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("&#300", 1'b1, 1'b0);
    endtask

    // Zero limit drops everything; a small limit truncates mid-text
    task automatic test_output_limit();
        write_limit(0);
        send_text("a", 1'b1, 1'b0);
        write_limit(2);
        send_text("abc", 1'b1, 1'b0);
    endtask

    // Receiver holds off for a long stretch while flush-heavy text keeps
    // coming, so the request queue fills and the input stalls
    task automatic test_backpressure();
        write_limit(MAX_KEPT);
        hold_req++;
        repeat (6)
        begin
            send_text("&quo", 1'b0, 1'b0);
            send_byte("!", 1'b0);
        end
        send_text("&amp", 1'b1, 1'b0);
    endtask

    // Terminator of a numeric entity: mostly ';', else any byte
    task automatic send_terminator();
        if ($urandom_range(0, 9) < 6)
            send_byte(";", pick_eot());
        else
            send_byte(8'($urandom_range(0, 255)), pick_eot());
    endtask

    // One random piece of text: mostly well-formed entities with random
    // content, plus noise bytes and broken sequences
    task automatic send_random_piece();
        int    kind;
        int    idx;
        int    v;
        int    cut;
        string s;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            send_byte(8'($urandom_range(0, 255)), pick_eot());
        end
        else if (kind < 45)
        begin
            idx = $urandom_range(0, 5);
            send_text({"&", ent_name[idx]}, 1'b0, 1'b1);
        end
        else if (kind < 65)
        begin
            v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99999) : $urandom_range(0, 200);
            s = ($urandom_range(0, 3) == 0) ? $sformatf("%05d", v) : $sformatf("%0d", v);
            if ($urandom_range(0, 4) == 0)
                s = "";
            send_text({"&#", s}, 1'b0, 1'b1);
            send_terminator();
        end
        else if (kind < 80)
        begin
            v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 160);
            s = ($urandom_range(0, 1) == 0) ? "x" : "X";
            send_text({"&#", s, $sformatf("%0h", v)}, 1'b0, 1'b1);
            send_terminator();
        end
        else if (kind < 95)
        begin
            // name prefix that breaks off on an arbitrary byte
            idx = $urandom_range(0, 5);
            cut = $urandom_range(0, ent_name[idx].len() - 2);
            send_text({"&", ent_name[idx].substr(0, cut)}, 1'b0, 1'b1);
            send_byte(8'($urandom_range(0, 255)), pick_eot());
        end
        else
        begin
            send_text("&#", 1'b0, 1'b1);
            send_byte(8'($urandom_range(0, 255)), pick_eot());
        end
    endtask

    // Random text in phases; each phase runs under a new limit, written
    // wherever the text happens to be, so some changes land mid-text
    task automatic test_random_text();
        int phase_lim [N_PHASES];
        int start;
        phase_lim[0] = MAX_KEPT;
        phase_lim[1] = 0;
        phase_lim[2] = 3;
        phase_lim[3] = $urandom_range(1, 20);
        phase_lim[4] = 255;
        phase_lim[5] = $urandom_range(0, 4095);
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_limit(phase_lim[p]);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                send_random_piece();
        end
    endtask

    task automatic finish_run();
        in_valid = 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        char_in      = '0;
        end_of_text  = 1'b0;
        res_stall    = 1'b0;
        cfg_valid    = 1'b0;
        output_limit = '0;
        clear_text_state();
        limit_reg = 255;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_entity_forms();
        test_byte_extremes();
        test_output_limit();
        test_backpressure();
        test_random_text();
        finish_run();
    end

endmodule
